>>> hw/rtl/smpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants for the sorted min priority queue
// Holds the data widths, the command codes and the structs that pass
// between the cells of the sorted chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

	// Width of one stored value and of the reported count field.
	localparam int DATA_W           = 32;
	localparam int COUNT_W          = 5;
	localparam int CAPACITY_DEFAULT = 16;

	// Operation carried in the input tuser.
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} smpq_cmd_t;

	// What one cell shows to its neighbors.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              valid;
		logic              ge;    // valid and stored value >= incoming value
	} smpq_link_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic              push;  // accepted push that fits
		logic              pop;   // accepted pop of a non-empty store
		logic [DATA_W-1:0] value;
	} smpq_op_t;

endpackage : smpq_pkg
`default_nettype wire

>>> hw/rtl/smpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one value and its valid bit. On a push it keeps its value, takes the
// value of its left neighbor, or takes the new value; on a pop it takes the
// value of its right neighbor.
// ----------------------------------------------------------------------------
module smpq_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  smpq_pkg::smpq_op_t      op,
	input  smpq_pkg::smpq_link_t    left_in,
	input  smpq_pkg::smpq_link_t    right_in,
	output smpq_pkg::smpq_link_t    link_out
);
	import smpq_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic              valid_q;
	logic              ge;
	logic              insert_here;

	// Compare against the incoming value; sorted order makes the first
	// cell that is >= (or the first empty cell) the insertion point.
	assign ge          = valid_q && ($signed(value_q) >= $signed(op.value));
	assign insert_here = left_in.valid && !left_in.ge && (ge || !valid_q);

	assign link_out.value = value_q;
	assign link_out.valid = valid_q;
	assign link_out.ge    = ge;

	// Valid bits track the occupied prefix of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.push) begin
			valid_q <= valid_q | left_in.valid;
		end else if (op.pop) begin
			valid_q <= right_in.valid;
		end
	end

	// Payload moves right on a push and left on a pop.
	always_ff @(posedge clk) begin
		if (op.push) begin
			if (left_in.ge) begin
				value_q <= left_in.value;
			end else if (insert_here) begin
				value_q <= op.value;
			end
		end else if (op.pop) begin
			value_q <= right_in.value;
		end
	end

endmodule : smpq_cell
`default_nettype wire

>>> hw/rtl/sorted_min_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: bounded min priority queue as a sorted chain
// Push inserts a signed value in front of the first stored value that is
// greater than or equal to it; pop returns the smallest value.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells, each holding one value; every cell
// compares its value with the incoming one in parallel and moves its data at
// most one place left or right, and a new beat can be accepted in every cycle
// as long as the result register is free or being drained. Each accepted beat
// yields exactly one result beat. Popping an empty store returns -1 with the
// empty flag; a push into a full store is dropped with the full flag.
// entry_count is the count after the operation, kept to its five bits.
module sorted_min_priority_queue #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Command input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic        s_axis_tuser,   // [0] command
	// Result output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] popped_value, [36:32] entry_count
	output logic [1:0]       m_axis_tuser    // [0] was_empty, [1] was_full
);
	import smpq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	smpq_link_t        cell_link [CAPACITY];
	smpq_link_t        left_link [CAPACITY];
	smpq_link_t        right_link[CAPACITY];
	smpq_op_t          op;
	logic              accept;
	logic              is_pop;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic [CNT_W+COUNT_W-1:0] count_ext;
	logic              out_valid_q;
	logic [DATA_W-1:0] popped_q;
	logic              was_empty_q;
	logic              was_full_q;
	logic [COUNT_W-1:0] count_out_q;
	logic [CAPACITY-1:0] valid_vec;

	// Input handshake: the result register is free or drains this cycle.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_pop        = (smpq_cmd_t'(s_axis_tuser) == CMD_POP);

	assign full  = cell_link[CAPACITY-1].valid;
	assign empty = !cell_link[0].valid;

	assign op.push  = accept && !is_pop && !full;
	assign op.pop   = accept && is_pop && !empty;
	assign op.value = s_axis_tdata;

	// Chain of cells with fixed ends.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_link[i] = '{value: '0, valid: 1'b1, ge: 1'b0};
		end else begin : g_mid_l
			assign left_link[i] = cell_link[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_link[i] = '{value: '0, valid: 1'b0, ge: 1'b0};
		end else begin : g_mid_r
			assign right_link[i] = cell_link[i+1];
		end
		assign valid_vec[i] = cell_link[i].valid;

		smpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.left_in  (left_link[i]),
			.right_in (right_link[i]),
			.link_out (cell_link[i])
		);
	end

	// Count of stored values.
	always_comb begin
		count_next = count_q;
		if (op.push) begin
			count_next = count_q + CNT_W'(1);
		end else if (op.pop) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_next};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_pop) begin
				popped_q <= empty ? '1 : cell_link[0].value;
			end else begin
				popped_q <= '0;
			end
			was_empty_q <= is_pop && empty;
			was_full_q  <= !is_pop && full;
			count_out_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, count_out_q, popped_q};
	assign m_axis_tuser  = {was_full_q, was_empty_q};

	// The count always matches the number of occupied cells.
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("count does not match occupied cells");

	// Occupied cells form one contiguous run in the chain.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec & ~(valid_vec >> 1)))
		else $error("occupied cells are not contiguous");

	// The two smallest values stay in order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cell_link[1].valid |-> $signed(cell_link[0].value) <= $signed(cell_link[1].value))
		else $error("head of chain out of order");

	// An empty flag always comes with the all-ones value.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF))
		else $error("empty pop without all-ones value");

endmodule : sorted_min_priority_queue
`default_nettype wire
